// ===== design/bta_pkg.sv =====
package bta_pkg;

  localparam int CLIENT_W        = 5;
  localparam int TICKET_W        = 8;
  localparam int STATUS_W        = 2;
  localparam int NUM_CLIENTS_DEF = 32;

  localparam logic [TICKET_W-1:0] TICKET_NONE = '0;
  localparam logic [TICKET_W-1:0] TICKET_MAX  = '1;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTICKET = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

endpackage

// ===== design/bta_in_if.sv =====
interface bta_in_if import bta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CLIENT_W-1:0] client;

  modport source (output valid, kind, client, input ready);
  modport sink   (input valid, kind, client, output ready);
endinterface

// ===== design/bta_out_if.sv =====
interface bta_out_if import bta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TICKET_W-1:0] ticket_given;
  logic                grant_valid;
  logic [CLIENT_W-1:0] grant_client;
  logic [STATUS_W-1:0] status;

  modport source (output valid, ticket_given, grant_valid, grant_client, status,
                  input ready);
  modport sink   (input valid, ticket_given, grant_valid, grant_client, status,
                  output ready);
endinterface

// ===== design/bta_ticket_mem.sv =====
module bta_ticket_mem import bta_pkg::*; #(
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF,
  parameter int IDX_W       = $clog2(NUM_CLIENTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output logic [TICKET_W-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [TICKET_W-1:0] wr_data_i
);

  logic [TICKET_W-1:0]    mem_q [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] vld_q;
  logic [TICKET_W-1:0]    rdat_q;
  logic                   rvld_q;

  // storage array, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdat_q <= mem_q[rd_addr_i];
    end
  end

  // entry valid bits: a never-written entry reads as no ticket
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdat_q : TICKET_NONE;

endmodule

// ===== design/bakery_ticket_arbiter.sv =====
// Ticket arbiter after the bakery lock. Each client holds one 8-bit ticket in
// an on-chip memory, zero meaning idle. An acquire item gives the client a
// ticket one above the largest held (saturating at 255, flagged), a release
// item clears it; after every item one result reports the ticket given, the
// grant holder (smallest nonzero ticket, ties to the lower client number) and
// a status code. An accepted item passes a sweep state (S_SCAN), a drain state
// (S_DRAIN) and a finish state (S_FINISH) that writes back and registers the
// result once the output register is free. The memory has a single read port,
// so every item sweeps all entries one a cycle, then writes back once. Items
// are handled one at a time; a new item is accepted while the previous result
// still waits in the output register. No clearing pass is needed after reset.
module bakery_ticket_arbiter import bta_pkg::*; #(
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bta_in_if.sink       in_i,
  bta_out_if.source    out_o
);

  localparam int IDX_W = $clog2(NUM_CLIENTS);
  localparam int EXT_W = ((IDX_W > CLIENT_W) ? IDX_W : CLIENT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);

  state_e state_q, state_d;

  // item under work
  logic                kind_q;
  logic [CLIENT_W-1:0] client_q;
  logic [EXT_W-1:0]    client_ext;
  logic                in_range;
  logic [IDX_W-1:0]    cidx;

  // sweep
  logic [IDX_W-1:0]    addr_q;
  logic [IDX_W-1:0]    rsp_idx_q;
  logic                rsp_vld_q;
  logic [TICKET_W-1:0] rd_data;

  // accumulators over the sweep
  logic [TICKET_W-1:0] max_q, max_d;
  logic [TICKET_W-1:0] own_q, own_d;
  logic [TICKET_W-1:0] min_q, min_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    who_q, who_d;

  // sequencer outputs
  logic accept, rd_en, fin, out_free;

  // write-back and result
  logic [TICKET_W-1:0] new_own;
  logic [TICKET_W-1:0] given;
  logic [TICKET_W-1:0] next_ticket;
  logic                mem_we;
  status_e             status;
  logic                take_self;
  logic [TICKET_W-1:0] self_t;
  logic [IDX_W-1:0]    grant_idx;
  logic [EXT_W-1:0]    grant_ext;

  logic                out_vld_q;
  logic [TICKET_W-1:0] out_given_q;
  logic                out_gvld_q;
  logic [CLIENT_W-1:0] out_gcli_q;
  status_e             out_status_q;

  assign client_ext = EXT_W'(client_q);
  assign in_range   = client_ext < EXT_W'(NUM_CLIENTS);
  assign cidx       = client_ext[IDX_W-1:0];
  assign out_free   = !out_vld_q || out_o.ready;

  bta_ticket_mem #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (cidx),
    .wr_data_i (new_own)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_SCAN;
      S_SCAN:   if (addr_q == LAST_IDX) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    fin        = 1'b0;
    case (state_q)
      S_IDLE:   in_i.ready = 1'b1;
      S_SCAN:   rd_en = 1'b1;
      S_DRAIN:  ;
      S_FINISH: fin = out_free;
      default:  ;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rsp_vld_q <= rd_en;
    end
  end

  // fold one returned entry into the running maximum and the holder search;
  // the requester's own entry is kept apart since it changes at write-back
  always_comb begin
    max_d   = max_q;
    own_d   = own_q;
    min_d   = min_q;
    found_d = found_q;
    who_d   = who_q;
    if (rsp_vld_q) begin
      if (rd_data > max_q) max_d = rd_data;
      if (in_range && rsp_idx_q == cidx) begin
        own_d = rd_data;
      end else if (rd_data != TICKET_NONE && (!found_q || rd_data < min_q)) begin
        min_d   = rd_data;
        found_d = 1'b1;
        who_d   = rsp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_i.kind;
      client_q <= in_i.client;
      addr_q   <= '0;
      max_q    <= TICKET_NONE;
      own_q    <= TICKET_NONE;
      min_q    <= TICKET_NONE;
      found_q  <= 1'b0;
      who_q    <= '0;
    end else begin
      if (rd_en) addr_q <= addr_q + IDX_W'(1);
      rsp_idx_q <= addr_q;
      max_q     <= max_d;
      own_q     <= own_d;
      min_q     <= min_d;
      found_q   <= found_d;
      who_q     <= who_d;
    end
  end

  // decide the item once the sweep is complete
  assign next_ticket = (max_q == TICKET_MAX) ? TICKET_MAX : max_q + TICKET_W'(1);

  always_comb begin
    new_own = own_q;
    given   = TICKET_NONE;
    status  = ST_OK;
    mem_we  = 1'b0;
    if (kind_q == KIND_ACQUIRE) begin
      if (!in_range || own_q != TICKET_NONE) begin
        status = ST_DUP;
      end else begin
        new_own = next_ticket;
        given   = next_ticket;
        mem_we  = fin;
        if (max_q == TICKET_MAX) status = ST_SAT;
      end
    end else begin
      if (!in_range || own_q == TICKET_NONE) begin
        status = ST_NOTICKET;
      end else begin
        new_own = TICKET_NONE;
        mem_we  = fin;
      end
    end
  end

  // merge the requester's new ticket with the best of the others
  assign self_t    = in_range ? new_own : TICKET_NONE;
  assign take_self = (self_t != TICKET_NONE) &&
                     (!found_q || self_t < min_q || (self_t == min_q && cidx < who_q));
  assign grant_idx = take_self ? cidx : who_q;
  assign grant_ext = EXT_W'(grant_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_given_q  <= given;
      out_gvld_q   <= take_self || found_q;
      out_gcli_q   <= (take_self || found_q) ? grant_ext[CLIENT_W-1:0] : '0;
      out_status_q <= status;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.ticket_given = out_given_q;
  assign out_o.grant_valid  = out_gvld_q;
  assign out_o.grant_client = out_gcli_q;
  assign out_o.status       = out_status_q;

  // reads and the write-back never overlap, so no forwarding is needed
  a_write_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_FINISH && !rd_en && !rsp_vld_q)
    else $error("ticket write outside write-back");

  a_rsp_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> state_q == S_SCAN || state_q == S_DRAIN)
    else $error("read data returned outside sweep");

  a_accept_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_SCAN && addr_q == '0)
    else $error("accepted item did not start a sweep");

  a_sat_gives_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q == ST_SAT |-> out_given_q == TICKET_MAX)
    else $error("saturated result without top ticket");

  a_given_has_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_given_q != TICKET_NONE |-> out_gvld_q)
    else $error("ticket given but no grant holder");

endmodule
